### hw/rtl/bcdec_pkg.sv
`timescale 1ns / 1ps

package bcdec_pkg;

  // defaults for the top level parameters
  localparam int MaxImageSizeDef = 4096;
  localparam int QueueDepthDef   = 2;

  // register indexes on the configuration port
  localparam logic [1:0] RegFormat = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  // reset values
  localparam logic        FormatRst = 1'b0;
  localparam logic [12:0] WidthRst  = 13'd4096;
  localparam logic [12:0] HeightRst = 13'd4096;

  // reciprocal multipliers for exact floor division over the ranges in use
  localparam int Recip3 = 683;
  localparam int Shift3 = 11;
  localparam int Recip5 = 3277;
  localparam int Shift5 = 14;
  localparam int Recip7 = 2341;
  localparam int Shift7 = 14;

  typedef struct packed {
    logic [9:0]  block_col;
    logic [9:0]  block_row;
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_codes;
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [47:0] alpha_codes;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic        bc3;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  // one classified block, palettes resolved
  typedef struct packed {
    logic [9:0]       block_col;
    logic [9:0]       block_row;
    logic [3:0][7:0]  red;
    logic [3:0][7:0]  green;
    logic [3:0][7:0]  blue;
    logic [7:0][7:0]  alev;
    logic             four;
    logic             bc3;
    logic [31:0]      color_codes;
    logic [47:0]      alpha_codes;
    logic [15:0]      mask;
  } blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // valid for v up to 765
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'(Recip3);
    return p[Shift3 +: 8];
  endfunction

  // valid for v up to 1277
  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [23:0] p;
    p = 24'(v) * 24'(Recip5);
    return p[Shift5 +: 8];
  endfunction

  // valid for v up to 1788
  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [23:0] p;
    p = 24'(v) * 24'(Recip7);
    return p[Shift7 +: 8];
  endfunction

endpackage

### hw/rtl/bcdec_front.sv
`timescale 1ns / 1ps

module bcdec_front #(
  parameter int MAX_IMAGE_SIZE = bcdec_pkg::MaxImageSizeDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bcdec_pkg::cfg_t     cfg,
  input  logic                in_push,
  output logic                in_full,
  input  bcdec_pkg::in_item_t in_item,
  output logic                blk_push,
  input  logic                blk_full,
  output bcdec_pkg::blk_t     blk
);
  import bcdec_pkg::*;

  logic              s1_valid_r;
  logic [9:0]        col_r;
  logic [9:0]        row_r;
  logic [31:0]       ccodes_r;
  logic [47:0]       acodes_r;
  logic [15:0]       mask_r;
  logic              four_r;
  logic              eight_r;
  logic              bc3_r;
  logic [2:0][7:0]   c0_r;
  logic [2:0][7:0]   c1_r;
  logic [2:0][9:0]   s2_r;
  logic [2:0][9:0]   s3_r;
  logic [7:0]        a0_r;
  logic [7:0]        a1_r;
  logic [5:0][10:0]  asum_r;

  logic [2:0][7:0]   c0;
  logic [2:0][7:0]   c1;
  logic [2:0][9:0]   s2;
  logic [2:0][9:0]   s3;
  logic [5:0][10:0]  asum;
  logic              four;
  logic              eight;
  logic [3:0]        col_ok;
  logic [3:0]        row_ok;
  logic [15:0]       mask;
  logic              in_take;
  logic              s1_adv;
  logic [2:0][3:0][7:0] pal;
  logic [7:0][7:0]   alev;

  // endpoints, weighted sums and in-bounds mask
  always_comb begin
    c0[0] = widen5(in_item.color_end0[15:11]);
    c0[1] = widen6(in_item.color_end0[10:5]);
    c0[2] = widen5(in_item.color_end0[4:0]);
    c1[0] = widen5(in_item.color_end1[15:11]);
    c1[1] = widen6(in_item.color_end1[10:5]);
    c1[2] = widen5(in_item.color_end1[4:0]);
    four  = in_item.color_end0 > in_item.color_end1;
    eight = in_item.alpha_end0 > in_item.alpha_end1;
    for (int ch = 0; ch < 3; ch++) begin
      if (four) begin
        s2[ch] = 10'({c0[ch], 1'b0}) + 10'(c1[ch]);
      end else begin
        s2[ch] = 10'(c0[ch]) + 10'(c1[ch]);
      end
      s3[ch] = 10'(c0[ch]) + 10'({c1[ch], 1'b0});
    end
    for (int k = 0; k < 6; k++) begin
      if (eight) begin
        asum[k] = 11'((6 - k) * int'(in_item.alpha_end0) +
                      (1 + k) * int'(in_item.alpha_end1) + 3);
      end else if (k < 4) begin
        asum[k] = 11'((4 - k) * int'(in_item.alpha_end0) +
                      (1 + k) * int'(in_item.alpha_end1) + 2);
      end else begin
        asum[k] = '0;
      end
    end
    for (int c = 0; c < 4; c++) begin
      col_ok[c] = ({1'b0, in_item.block_col, 2'(c)} < cfg.image_width) &&
                  (32'({in_item.block_col, 2'(c)}) < 32'(MAX_IMAGE_SIZE));
      row_ok[c] = ({1'b0, in_item.block_row, 2'(c)} < cfg.image_height) &&
                  (32'({in_item.block_row, 2'(c)}) < 32'(MAX_IMAGE_SIZE));
    end
    for (int i = 0; i < 16; i++) begin
      mask[i] = col_ok[i % 4] & row_ok[i / 4];
    end
  end

  // blocks wholly outside the image are dropped here
  assign s1_adv   = s1_valid_r && ((mask_r == '0) || !blk_full);
  assign in_full  = s1_valid_r && !s1_adv;
  assign in_take  = in_push && !in_full;
  assign blk_push = s1_valid_r && (mask_r != '0) && !blk_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      col_r    <= in_item.block_col;
      row_r    <= in_item.block_row;
      ccodes_r <= in_item.color_codes;
      acodes_r <= in_item.alpha_codes;
      mask_r   <= mask;
      four_r   <= four;
      eight_r  <= eight;
      bc3_r    <= cfg.bc3;
      c0_r     <= c0;
      c1_r     <= c1;
      s2_r     <= s2;
      s3_r     <= s3;
      a0_r     <= in_item.alpha_end0;
      a1_r     <= in_item.alpha_end1;
      asum_r   <= asum;
    end
  end

  // palette, alpha levels by reciprocal multiply or shift
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pal[ch][0] = c0_r[ch];
      pal[ch][1] = c1_r[ch];
      pal[ch][2] = four_r ? div3(s2_r[ch]) : s2_r[ch][8:1];
      pal[ch][3] = four_r ? div3(s3_r[ch]) : 8'd0;
    end
    alev[0] = a0_r;
    alev[1] = a1_r;
    for (int k = 0; k < 6; k++) begin
      if (eight_r) begin
        alev[k + 2] = div7(asum_r[k]);
      end else if (k < 4) begin
        alev[k + 2] = div5(asum_r[k]);
      end else if (k == 4) begin
        alev[k + 2] = 8'd0;
      end else begin
        alev[k + 2] = 8'd255;
      end
    end
    blk.block_col   = col_r;
    blk.block_row   = row_r;
    blk.red         = pal[0];
    blk.green       = pal[1];
    blk.blue        = pal[2];
    blk.alev        = alev;
    blk.four        = four_r;
    blk.bc3         = bc3_r;
    blk.color_codes = ccodes_r;
    blk.alpha_codes = acodes_r;
    blk.mask        = mask_r;
  end

endmodule

### hw/rtl/bcdec_queue.sv
`timescale 1ns / 1ps

module bcdec_queue #(
  parameter int DEPTH = bcdec_pkg::QueueDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  bcdec_pkg::blk_t din,
  input  logic            pop,
  output logic            empty,
  output bcdec_pkg::blk_t dout
);
  import bcdec_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  blk_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_r;
  logic [PtrW-1:0] rd_r;
  logic [CntW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full    = cnt_r == CntW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

### hw/rtl/bcdec_back.sv
`timescale 1ns / 1ps

module bcdec_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 blk_empty,
  input  bcdec_pkg::blk_t      blk,
  output logic                 blk_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output bcdec_pkg::out_item_t out_item
);
  import bcdec_pkg::*;

  logic [15:0] done_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [15:0] pend;
  logic [15:0] pick;
  logic [3:0]  idx;
  logic [1:0]  ci;
  logic [2:0]  ai;
  logic        last;
  logic        load;
  logic        emit;
  out_item_t   pix;

  assign load    = !out_valid_r || out_pop;
  assign emit    = !blk_empty && load;
  assign blk_pop = emit && last;

  // next in-bounds pixel of the head block, lowest index first
  always_comb begin
    pend = blk.mask & ~done_r;
    pick = pend & (~pend + 16'd1);
    idx  = '0;
    for (int i = 0; i < 16; i++) begin
      if (pick[i]) begin
        idx = idx | 4'(i);
      end
    end
    last = (pend & ~pick) == '0;
    ci   = blk.color_codes[2*idx +: 2];
    ai   = blk.alpha_codes[3*idx +: 3];
    pix.pixel_x    = {blk.block_col, idx[1:0]};
    pix.pixel_y    = {blk.block_row, idx[3:2]};
    pix.red        = blk.red[ci];
    pix.green      = blk.green[ci];
    pix.blue       = blk.blue[ci];
    if (blk.bc3) begin
      pix.alpha = blk.alev[ai];
    end else if ((ci == 2'd3) && !blk.four) begin
      pix.alpha = 8'd0;
    end else begin
      pix.alpha = 8'd255;
    end
    pix.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        done_r <= last ? '0 : (done_r | pick);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= pix;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_item  = out_r;

endmodule

### hw/rtl/bc1_bc3_texture_block_decoder_unit.sv
`timescale 1ns / 1ps
// the first pixel of a block reaches the result ports through the input register, the block queue
//   and the pixel register when the path is clear
// throughput: one pixel per cycle from the single pixel output register while results are popped;
//   a block gives as many pixels as it has inside the image, 16 for a whole block
// blocks wholly outside the image are taken at one per cycle unless a stalled block is ahead, and leave no result
// reset (rst_n low, synchronous) empties all stages and sets BC1, 4096 x 4096

module bc1_bc3_texture_block_decoder_unit #(
  parameter int MAX_IMAGE_SIZE = bcdec_pkg::MaxImageSizeDef,
  parameter int QUEUE_DEPTH    = bcdec_pkg::QueueDepthDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // block requests
  input  logic                 in_push,
  output logic                 in_full,
  input  bcdec_pkg::in_item_t  in_item,
  // pixel results
  output logic                 out_empty,
  input  logic                 out_pop,
  output bcdec_pkg::out_item_t out_item,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bcdec_pkg::*;

  logic        fmt_r;
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic        cfg_wr;
  cfg_t        cfg;

  logic        blk_push;
  logic        blk_full;
  blk_t        blk_in;
  logic        blk_empty;
  logic        blk_pop;
  blk_t        blk_head;

  // register file, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FormatRst;
      width_r  <= WidthRst;
      height_r <= HeightRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegFormat: fmt_r    <= pwdata[0];
        RegWidth:  width_r  <= pwdata[12:0];
        RegHeight: height_r <= pwdata[12:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegFormat: prdata = {31'b0, fmt_r};
      RegWidth:  prdata = {19'b0, width_r};
      RegHeight: prdata = {19'b0, height_r};
      default:   prdata = '0;
    endcase
  end

  // settings used by the front end; user rule, unchecked by the block: only changed while the block is idle
  assign cfg.bc3          = fmt_r;
  assign cfg.image_width  = width_r;
  assign cfg.image_height = height_r;

  // front: takes requests, clips against the image, builds palettes
  bcdec_front #(
    .MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .blk_push (blk_push),
    .blk_full (blk_full),
    .blk      (blk_in)
  );

  // short queue of decoded blocks between the two halves
  bcdec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (blk_push),
    .full  (blk_full),
    .din   (blk_in),
    .pop   (blk_pop),
    .empty (blk_empty),
    .dout  (blk_head)
  );

  // back: walks the in-bounds pixels of the head block, one per cycle while results are popped
  bcdec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .blk_empty (blk_empty),
    .blk       (blk_head),
    .blk_pop   (blk_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### tb/sv/bc1_bc3_texture_block_decoder_unit_tb.sv
`timescale 1ns / 1ps

module bc1_bc3_texture_block_decoder_unit_tb;
  import bcdec_pkg::*;

  // write to this index must leave every register as it was
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int LongHold = 250;
  localparam int SettleCycles = 8;

  // expected pixel store plus the decode arithmetic that fills it
  class pixel_board;
    out_item_t pending[$];
    int errors;
    bit fmt_bc3;
    logic [12:0] img_w;
    logic [12:0] img_h;

    function new();
      errors = 0;
      fmt_bc3 = FormatRst;
      img_w = WidthRst;
      img_h = HeightRst;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        RegFormat: fmt_bc3 = val[0];
        RegWidth: img_w = val[12:0];
        RegHeight: img_h = val[12:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      return (img_w > MaxImageSizeDef) ? MaxImageSizeDef : img_w;
    endfunction

    function int unsigned eff_height();
      return (img_h > MaxImageSizeDef) ? MaxImageSizeDef : img_h;
    endfunction

    // expand one accepted block into the pixels it must produce
    function void note_block(in_item_t b);
      int unsigned pr[4], pg[4], pb[4], pa[4], alev[8];
      int unsigned a0, a1, x, y, ci, ai, w, h, before_n;
      bit four;
      out_item_t px;
      w = eff_width();
      h = eff_height();
      before_n = pending.size();
      four = b.color_end0 > b.color_end1;
      pr[0] = {b.color_end0[15:11], b.color_end0[15:13]};
      pg[0] = {b.color_end0[10:5], b.color_end0[10:9]};
      pb[0] = {b.color_end0[4:0], b.color_end0[4:2]};
      pr[1] = {b.color_end1[15:11], b.color_end1[15:13]};
      pg[1] = {b.color_end1[10:5], b.color_end1[10:9]};
      pb[1] = {b.color_end1[4:0], b.color_end1[4:2]};
      if (four) begin
        pr[2] = (2 * pr[0] + pr[1]) / 3;
        pg[2] = (2 * pg[0] + pg[1]) / 3;
        pb[2] = (2 * pb[0] + pb[1]) / 3;
        pr[3] = (pr[0] + 2 * pr[1]) / 3;
        pg[3] = (pg[0] + 2 * pg[1]) / 3;
        pb[3] = (pb[0] + 2 * pb[1]) / 3;
      end else begin
        pr[2] = (pr[0] + pr[1]) / 2;
        pg[2] = (pg[0] + pg[1]) / 2;
        pb[2] = (pb[0] + pb[1]) / 2;
        pr[3] = 0;
        pg[3] = 0;
        pb[3] = 0;
      end
      pa[0] = 255;
      pa[1] = 255;
      pa[2] = 255;
      pa[3] = four ? 255 : 0;
      a0 = b.alpha_end0;
      a1 = b.alpha_end1;
      alev[0] = a0;
      alev[1] = a1;
      if (a0 > a1) begin
        for (int i = 0; i < 6; i++)
          alev[2 + i] = ((6 - i) * a0 + (1 + i) * a1 + 3) / 7;
      end else begin
        for (int i = 0; i < 4; i++)
          alev[2 + i] = ((4 - i) * a0 + (1 + i) * a1 + 2) / 5;
        alev[6] = 0;
        alev[7] = 255;
      end
      for (int i = 0; i < 16; i++) begin
        x = b.block_col;
        x = x * 4 + (i & 3);
        y = b.block_row;
        y = y * 4 + (i >> 2);
        if (x >= w || y >= h) continue;
        ci = b.color_codes[2 * i +: 2];
        ai = b.alpha_codes[3 * i +: 3];
        px.pixel_x = x[11:0];
        px.pixel_y = y[11:0];
        px.red = pr[ci][7:0];
        px.green = pg[ci][7:0];
        px.blue = pb[ci][7:0];
        px.alpha = fmt_bc3 ? alev[ai][7:0] : pa[ci][7:0];
        px.last_pixel = 1'b0;
        pending.push_back(px);
      end
      if (pending.size() > before_n) pending[pending.size() - 1].last_pixel = 1'b1;
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: pixel expected none got %p", $time, got);
        return;
      end
      want = pending.pop_front();
      cmp("pixel_x", want.pixel_x, got.pixel_x);
      cmp("pixel_y", want.pixel_y, got.pixel_y);
      cmp("red", want.red, got.red);
      cmp("green", want.green, got.green);
      cmp("blue", want.blue, got.blue);
      cmp("alpha", want.alpha, got.alpha);
      cmp("last_pixel", want.last_pixel, got.last_pixel);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_item;
  logic out_empty;
  logic out_pop;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pixel_board board;
  // calm turns off idling on both sides for the closing stretch
  bit calm;
  // asks the pixel side for one long hold-off
  bit hold_req;
  int cycles;

  bc1_bc3_texture_block_decoder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // pixel side: pops with random stall bursts, plus one long hold-off on request
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop = 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_pop = 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_pop = 1'b1;
        @(posedge clk);
        if (rst_n && out_empty === 1'b0) board.check_pixel(out_item);
      end
    end
  end

  // all drive tasks start and end just after a falling edge

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.apply_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drop the request line and wait until every expected pixel has come out
  task automatic drain_pixels();
    in_push = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // idle point for register writes; blocks with no pixels may still be in flight
  task automatic settle();
    drain_pixels();
    repeat (SettleCycles) @(negedge clk);
  endtask

  // offer one block until taken, then maybe a random gap
  task automatic send_block(input in_item_t blk);
    in_item = blk;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    board.note_block(blk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_push = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  function automatic in_item_t make_block(logic [9:0] col, logic [9:0] row,
                                          logic [15:0] e0, logic [15:0] e1,
                                          logic [31:0] cc, logic [7:0] a0,
                                          logic [7:0] a1, logic [47:0] ac);
    in_item_t b;
    b.block_col = col;
    b.block_row = row;
    b.color_end0 = e0;
    b.color_end1 = e1;
    b.color_codes = cc;
    b.alpha_end0 = a0;
    b.alpha_end1 = a1;
    b.alpha_codes = ac;
    return b;
  endfunction

  // image sizes: a mix of ordinary, tiny, full and oversized, rarely zero
  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(1, 16);
      2, 3, 4: return $urandom_range(17, 4096);
      5, 6: return 4096;
      7, 8: return $urandom_range(4097, 8191);
      default: return 0;
    endcase
  endfunction

  function automatic in_item_t rand_block();
    in_item_t b;
    int unsigned w, h;
    w = board.eff_width();
    h = board.eff_height();
    // keep most blocks near a small image so they produce pixels
    b.block_col = (w <= 64 && $urandom_range(0, 4) != 0) ?
                  10'($urandom_range(0, (w + 3) / 4 + 1)) : 10'($urandom);
    b.block_row = (h <= 64 && $urandom_range(0, 4) != 0) ?
                  10'($urandom_range(0, (h + 3) / 4 + 1)) : 10'($urandom);
    b.color_end0 = 16'($urandom);
    b.color_end1 = ($urandom_range(0, 5) == 0) ? b.color_end0 : 16'($urandom);
    b.color_codes = $urandom;
    b.alpha_end0 = 8'($urandom);
    b.alpha_end1 = ($urandom_range(0, 5) == 0) ? b.alpha_end0 : 8'($urandom);
    b.alpha_codes = {16'($urandom), $urandom};
    return b;
  endfunction

  // alpha index i mod 8 at pixel i, each level shows up twice
  localparam logic [47:0] AlphaRamp = 48'hFAC688_FAC688;

  initial begin
    board = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // bc1 at reset size: both colour modes, equal endpoints, far corner
    send_block(make_block(0, 0, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 0, 0, 0));
    send_block(make_block(1, 2, 16'h0000, 16'hFFFF, 32'h1B1B_1B1B, 0, 0, 0));
    send_block(make_block(5, 7, 16'h7BEF, 16'h7BEF, 32'hFFFF_FFFF, 0, 0, 0));
    send_block(make_block(1023, 1023, 16'hF800, 16'h07E0, 32'h0000_0000,
                          8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF));
    send_block(make_block(1023, 0, 16'h001F, 16'hF81F, 32'h9C6B_3E21, 8'h55, 8'hAA,
                          48'h1234_5678_9ABC));
    send_block(make_block(0, 0, 0, 0, 0, 0, 0, 0));

    // bc3: eight-level, six-level, equal endpoints, three-colour colour part
    settle();
    write_reg(RegFormat, 32'd1);
    send_block(make_block(2, 3, 16'hF81F, 16'h07E0, 32'hE4E4_E4E4, 8'd255, 8'd0, AlphaRamp));
    send_block(make_block(3, 2, 16'h07E0, 16'hF81F, 32'hFFFF_0000, 8'd0, 8'd255, AlphaRamp));
    send_block(make_block(4, 4, 16'h1234, 16'h1234, 32'h5A5A_A5A5, 8'd128, 8'd128,
                          48'hFFFF_FFFF_FFFF));
    send_block(make_block(9, 1, 16'hABCD, 16'h4321, 32'h3C3C_C3C3, 8'd200, 8'd13, AlphaRamp));
    send_block(make_block(1, 9, 16'h4321, 16'hABCD, 32'hC3C3_3C3C, 8'd13, 8'd200, AlphaRamp));

    // small image: whole, partial, and wholly outside blocks
    settle();
    write_reg(RegWidth, 32'd6);
    write_reg(RegHeight, 32'd5);
    send_block(make_block(0, 0, 16'hC618, 16'h39E7, 32'hB1E4_4E1B, 8'd90, 8'd30, AlphaRamp));
    send_block(make_block(1, 0, 16'h39E7, 16'hC618, 32'h1E4B_E4B1, 8'd30, 8'd90, AlphaRamp));
    send_block(make_block(1, 1, 16'hFFE0, 16'h001F, 32'hFFFF_FFFF, 8'd7, 8'd250,
                          48'hFFFF_FFFF_FFFF));
    send_block(make_block(2, 0, 16'hFFFF, 16'h0000, 32'h0, 8'd1, 8'd2, 48'h0));
    send_block(make_block(0, 2, 16'hFFFF, 16'h0000, 32'h0, 8'd1, 8'd2, 48'h0));

    // single pixel image
    settle();
    write_reg(RegWidth, 32'd1);
    write_reg(RegHeight, 32'd1);
    send_block(make_block(0, 0, 16'h8410, 16'h8410, 32'h3, 8'd255, 8'd255, 48'h7));
    send_block(make_block(1, 0, 16'h8410, 16'h0410, 32'h3, 8'd255, 8'd255, 48'h7));

    // zero width: nothing comes out
    settle();
    write_reg(RegFormat, 32'd0);
    write_reg(RegWidth, 32'd0);
    write_reg(RegHeight, 32'd4096);
    send_block(make_block(0, 0, 16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 0, 0, 0));
    send_block(make_block(1023, 1023, 16'h0000, 16'hFFFF, 32'h1B1B_1B1B, 0, 0, 0));

    // oversized image acts as the maximum; unknown index changes nothing
    settle();
    write_reg(RegWidth, 32'd8191);
    write_reg(RegHeight, 32'd5000);
    write_reg(RegUnused, 32'hFFFF_FFFF);
    send_block(make_block(1023, 1023, 16'hF800, 16'h001F, 32'h6C93_936C, 0, 0, 0));
    settle();
    write_reg(RegWidth, 32'd4096);
    write_reg(RegHeight, 32'd4096);

    // random phases, each with its own setting
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(RegFormat, $urandom_range(0, 1));
      if (ph == 0) begin
        // full image so the block fills while the pixel side is held off
        write_reg(RegWidth, 32'd4096);
        write_reg(RegHeight, 32'd4096);
        hold_req = 1'b1;
      end else if (ph == 7) begin
        write_reg(RegWidth, $urandom_range(17, 4096));
        write_reg(RegHeight, $urandom_range(17, 4096));
        calm = 1'b1;
      end else begin
        write_reg(RegWidth, pick_size());
        write_reg(RegHeight, pick_size());
      end
      for (int k = 0; k < 11; k++) begin
        // one pause mid-phase until every expected pixel has come out
        if (ph == 3 && k == 7) drain_pixels();
        send_block(rand_block());
      end
    end

    in_push = 1'b0;
    drain_pixels();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
